### rtl/core/bl_pkg.sv
package bl_pkg;

  localparam int PulseW  = 12;
  localparam int DbW     = 10;
  localparam int FdW     = 11;
  localparam int TimeW   = 32;
  localparam int PerW    = 11;
  localparam int NumW    = 23;
  localparam int QuoW    = 12;
  localparam int RemW    = NumW - QuoW;
  localparam int CntW    = 4;
  localparam int PaddrW  = 5;
  localparam int PdataW  = 32;

  localparam logic [PerW-1:0] SlowPeriod = 11'd2000;
  localparam logic [PerW-1:0] FastPeriod = 11'd200;
  localparam logic [PerW-1:0] SpanDelta  = SlowPeriod - FastPeriod;

  localparam logic [2:0] REG_PULSE_MIN       = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX       = 3'd1;
  localparam logic [2:0] REG_PULSE_NEUTRAL   = 3'd2;
  localparam logic [2:0] REG_DEAD_BAND       = 3'd3;
  localparam logic [2:0] REG_FULL_DEFLECTION = 3'd4;

  typedef struct packed {
    logic [PulseW-1:0] pulse_min;
    logic [PulseW-1:0] pulse_max;
    logic [PulseW-1:0] pulse_neutral;
    logic [DbW-1:0]    dead_band;
    logic [FdW-1:0]    full_deflection;
  } cfg_t;

  typedef struct packed {
    logic            idle;
    logic            done;
    logic            led;
    logic [PerW-1:0] period;
  } lane_res_t;

endpackage

### rtl/core/bl_regs.sv
module bl_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bl_pkg::PaddrW-1:0]  paddr,
  input  logic [bl_pkg::PdataW-1:0]  pwdata,
  output logic [bl_pkg::PdataW-1:0]  prdata,
  output logic                       pready,
  output bl_pkg::cfg_t               cfg
);

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min       <= 12'd1100;
      cfg.pulse_max       <= 12'd1900;
      cfg.pulse_neutral   <= 12'd1500;
      cfg.dead_band       <= 10'd25;
      cfg.full_deflection <= 11'd400;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        bl_pkg::REG_PULSE_MIN:       cfg.pulse_min       <= pwdata[bl_pkg::PulseW-1:0];
        bl_pkg::REG_PULSE_MAX:       cfg.pulse_max       <= pwdata[bl_pkg::PulseW-1:0];
        bl_pkg::REG_PULSE_NEUTRAL:   cfg.pulse_neutral   <= pwdata[bl_pkg::PulseW-1:0];
        bl_pkg::REG_DEAD_BAND:       cfg.dead_band       <= pwdata[bl_pkg::DbW-1:0];
        bl_pkg::REG_FULL_DEFLECTION: cfg.full_deflection <= pwdata[bl_pkg::FdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bl_pkg::REG_PULSE_MIN:       prdata = 32'(cfg.pulse_min);
      bl_pkg::REG_PULSE_MAX:       prdata = 32'(cfg.pulse_max);
      bl_pkg::REG_PULSE_NEUTRAL:   prdata = 32'(cfg.pulse_neutral);
      bl_pkg::REG_DEAD_BAND:       prdata = 32'(cfg.dead_band);
      bl_pkg::REG_FULL_DEFLECTION: prdata = 32'(cfg.full_deflection);
      default:                     prdata = '0;
    endcase
  end

endmodule

### rtl/core/bl_lane.sv
module bl_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      take,
  input  logic [bl_pkg::TimeW-1:0]  now_ms,
  input  logic [bl_pkg::PulseW-1:0] pulse,
  input  bl_pkg::cfg_t              cfg,
  output bl_pkg::lane_res_t         res
);

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_PREP = 6'b000010,
    L_MUL  = 6'b000100,
    L_CHK  = 6'b001000,
    L_DIV  = 6'b010000,
    L_DONE = 6'b100000
  } lane_state_t;

  lane_state_t                state;
  logic [bl_pkg::TimeW-1:0]   now_q;
  logic [bl_pkg::PulseW-1:0]  pulse_q;
  logic [bl_pkg::PulseW-1:0]  gap;
  logic                       near;
  logic                       den_zero;
  logic                       den_neg;
  logic [bl_pkg::FdW-1:0]     den_q;
  logic [bl_pkg::NumW-1:0]    num;
  logic                       ovf;
  logic [bl_pkg::RemW-1:0]    rem;
  logic [bl_pkg::QuoW-1:0]    quo;
  logic [bl_pkg::CntW-1:0]    cnt;
  logic [bl_pkg::TimeW-1:0]   last;
  logic                       led;

  logic [bl_pkg::PulseW-1:0]  clamped;
  logic [bl_pkg::PulseW-1:0]  span;
  logic [bl_pkg::PulseW:0]    den_full;
  logic [bl_pkg::RemW:0]      trial;
  logic                       ge;
  logic [bl_pkg::PerW-1:0]    period;
  logic [bl_pkg::TimeW-1:0]   due;
  logic                       fire;
  logic                       led_next;

  always_comb begin
    if (pulse_q < cfg.pulse_min) begin
      clamped = cfg.pulse_min;
    end else if (pulse_q > cfg.pulse_max) begin
      clamped = cfg.pulse_max;
    end else begin
      clamped = pulse_q;
    end
  end

  assign span     = gap - bl_pkg::PulseW'(cfg.dead_band);
  assign den_full = (bl_pkg::PulseW+1)'(cfg.full_deflection)
                  - (bl_pkg::PulseW+1)'(cfg.dead_band);
  assign trial    = {rem, quo[bl_pkg::QuoW-1]};
  assign ge       = trial >= (bl_pkg::RemW+1)'(den_q);

  always_comb begin
    if (near || den_zero) begin
      period = '0;
    end else if (den_neg) begin
      period = bl_pkg::SlowPeriod;
    end else if (ovf || quo >= bl_pkg::QuoW'(bl_pkg::SlowPeriod)) begin
      period = '0;
    end else begin
      period = bl_pkg::SlowPeriod - quo[bl_pkg::PerW-1:0];
    end
  end

  assign due      = last + bl_pkg::TimeW'(period >> 1);
  assign fire     = now_q > due;
  assign led_next = (period == '0) ? 1'b1 : (led ^ fire);

  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        now_q   <= now_ms;
        pulse_q <= pulse;
      end
      L_PREP: begin
        gap <= (clamped >= cfg.pulse_neutral) ? clamped - cfg.pulse_neutral
                                              : cfg.pulse_neutral - clamped;
      end
      L_MUL: begin
        near     <= gap <= bl_pkg::PulseW'(cfg.dead_band);
        den_zero <= den_full == '0;
        den_neg  <= den_full[bl_pkg::PulseW];
        den_q    <= den_full[bl_pkg::FdW-1:0];
        num      <= bl_pkg::NumW'(span) * bl_pkg::NumW'(bl_pkg::SpanDelta);
      end
      L_CHK: begin
        ovf <= num[bl_pkg::NumW-1:bl_pkg::QuoW] >= den_q;
        rem <= num[bl_pkg::NumW-1:bl_pkg::QuoW];
        quo <= num[bl_pkg::QuoW-1:0];
      end
      L_DIV: begin
        rem <= ge ? bl_pkg::RemW'(trial - (bl_pkg::RemW+1)'(den_q))
                  : trial[bl_pkg::RemW-1:0];
        quo <= {quo[bl_pkg::QuoW-2:0], ge};
      end
      L_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
      last  <= '0;
      led   <= 1'b0;
    end else begin
      unique case (state)
        L_IDLE: if (start) state <= L_PREP;
        L_PREP: state <= L_MUL;
        L_MUL:  state <= L_CHK;
        L_CHK: begin
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == bl_pkg::CntW'(bl_pkg::QuoW - 1)) state <= L_DONE;
        end
        L_DONE: begin
          if (take) begin
            led <= led_next;
            if (period != '0 && fire) last <= now_q;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign res.idle   = state == L_IDLE;
  assign res.done   = state == L_DONE;
  assign res.led    = led_next;
  assign res.period = period;

endmodule

### rtl/core/dual_pwm_speed_led_blinker.sv
// Two-channel servo pulse to LED blink indicator. Each input transfer carries
// the millisecond time and a left and a right pulse width; each produces one
// output transfer with both LED levels and both blink periods (0 = solid on).
// Two lanes run side by side, each doing clamp, distance, one multiply and a
// 12-step restoring divide at one quotient bit per cycle. The next item is
// taken once both lanes are free, while the last result may still wait in
// the output register. Registers sit on an APB-style port at byte addresses
// 0, 4, 8, 12 and 16; the user must write them only while the block is idle,
// as the block itself does not enforce it.
module dual_pwm_speed_led_blinker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bl_pkg::PaddrW-1:0]  paddr,
  input  logic [bl_pkg::PdataW-1:0]  pwdata,
  output logic [bl_pkg::PdataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bl_pkg::TimeW-1:0]   now_ms,
  input  logic [bl_pkg::PulseW-1:0]  pulse_left,
  input  logic [bl_pkg::PulseW-1:0]  pulse_right,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       led_left,
  output logic                       led_right,
  output logic [bl_pkg::PerW-1:0]    period_left,
  output logic [bl_pkg::PerW-1:0]    period_right
);

  bl_pkg::cfg_t      cfg;
  bl_pkg::lane_res_t res_l;
  bl_pkg::lane_res_t res_r;
  logic              start;
  logic              take;

  bl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bl_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .take   (take),
    .now_ms (now_ms),
    .pulse  (pulse_left),
    .cfg    (cfg),
    .res    (res_l)
  );

  bl_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .take   (take),
    .now_ms (now_ms),
    .pulse  (pulse_right),
    .cfg    (cfg),
    .res    (res_r)
  );

  assign in_stall = !(res_l.idle && res_r.idle);
  assign start    = in_valid && !in_stall;
  assign take     = res_l.done && res_r.done && (!out_valid || !out_stall);

  // merge both lanes into one output transfer
  always_ff @(posedge clk) begin
    if (take) begin
      led_left     <= res_l.led;
      led_right    <= res_r.led;
      period_left  <= res_l.period;
      period_right <= res_r.period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("lanes not busy after input transfer");

  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (res_l.done == res_r.done) && (res_l.idle == res_r.idle))
    else $error("lanes out of step");

  a_solid_left: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_left == '0) |-> led_left)
    else $error("left LED off with solid period");

  a_solid_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_right == '0) |-> led_right)
    else $error("right LED off with solid period");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_CAP = 50;
  localparam longint SLOW_MS = 2000;
  localparam longint FAST_MS = 200;

  typedef struct {
    logic                    led_left;
    logic                    led_right;
    logic [bl_pkg::PerW-1:0] period_left;
    logic [bl_pkg::PerW-1:0] period_right;
  } lamp_word_t;

  class lamp_scoreboard;
    logic [bl_pkg::PulseW-1:0] pulse_min;
    logic [bl_pkg::PulseW-1:0] pulse_max;
    logic [bl_pkg::PulseW-1:0] pulse_neutral;
    logic [bl_pkg::DbW-1:0]    dead_band;
    logic [bl_pkg::FdW-1:0]    full_deflection;
    logic [bl_pkg::TimeW-1:0]  last_toggle[2];
    logic                      led_level[2];
    lamp_word_t                awaited_lamps[$];
    int                        errors;

    function new();
      pulse_min = 12'd1100;
      pulse_max = 12'd1900;
      pulse_neutral = 12'd1500;
      dead_band = 10'd25;
      full_deflection = 11'd400;
      last_toggle[0] = '0;
      last_toggle[1] = '0;
      led_level[0] = 1'b0;
      led_level[1] = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [bl_pkg::PdataW-1:0] value);
      case (idx)
        bl_pkg::REG_PULSE_MIN:       pulse_min = value[bl_pkg::PulseW-1:0];
        bl_pkg::REG_PULSE_MAX:       pulse_max = value[bl_pkg::PulseW-1:0];
        bl_pkg::REG_PULSE_NEUTRAL:   pulse_neutral = value[bl_pkg::PulseW-1:0];
        bl_pkg::REG_DEAD_BAND:       dead_band = value[bl_pkg::DbW-1:0];
        bl_pkg::REG_FULL_DEFLECTION: full_deflection = value[bl_pkg::FdW-1:0];
        default: ;
      endcase
    endfunction

    function logic [bl_pkg::PerW-1:0] blink_period(logic [bl_pkg::PulseW-1:0] pulse);
      longint p, gap, span, q, per;
      p = pulse;
      if (p < longint'(pulse_min)) p = pulse_min;
      else if (p > longint'(pulse_max)) p = pulse_max;
      gap = p - longint'(pulse_neutral);
      if (gap < 0) gap = -gap;
      if (gap <= longint'(dead_band)) return '0;
      span = longint'(full_deflection) - longint'(dead_band);
      if (span == 0) return '0;
      q = ((gap - longint'(dead_band)) * (FAST_MS - SLOW_MS)) / span;
      per = q + SLOW_MS;
      if (per <= 0) return '0;
      if (per > SLOW_MS) per = SLOW_MS;
      return per[bl_pkg::PerW-1:0];
    endfunction

    function void advance_lane(int lane, logic [bl_pkg::TimeW-1:0] now,
                               logic [bl_pkg::PerW-1:0] per);
      logic [bl_pkg::TimeW-1:0] due;
      if (per != 0) begin
        due = last_toggle[lane] + (per >> 1);
        if (now > due) begin
          last_toggle[lane] = now;
          led_level[lane] = ~led_level[lane];
        end
      end else begin
        led_level[lane] = 1'b1;
      end
    endfunction

    function void note_transfer(logic [bl_pkg::TimeW-1:0] now,
                                logic [bl_pkg::PulseW-1:0] left,
                                logic [bl_pkg::PulseW-1:0] right);
      lamp_word_t w;
      w.period_left = blink_period(left);
      w.period_right = blink_period(right);
      advance_lane(0, now, w.period_left);
      advance_lane(1, now, w.period_right);
      w.led_left = led_level[0];
      w.led_right = led_level[1];
      awaited_lamps.push_back(w);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_transfer(logic ll, logic lr, logic [bl_pkg::PerW-1:0] pl,
                        logic [bl_pkg::PerW-1:0] pr);
      lamp_word_t w;
      if (awaited_lamps.size() == 0) begin
        report_mismatch("output transfer with nothing awaited");
      end else begin
        w = awaited_lamps.pop_front();
        if (ll !== w.led_left)
          report_mismatch($sformatf("led_left %0b, want %0b", ll, w.led_left));
        if (lr !== w.led_right)
          report_mismatch($sformatf("led_right %0b, want %0b", lr, w.led_right));
        if (pl !== w.period_left)
          report_mismatch($sformatf("period_left %0d, want %0d", pl, w.period_left));
        if (pr !== w.period_right)
          report_mismatch($sformatf("period_right %0d, want %0d", pr, w.period_right));
      end
    endtask

    function int pending();
      return awaited_lamps.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [bl_pkg::PaddrW-1:0] paddr;
  logic [bl_pkg::PdataW-1:0] pwdata;
  logic [bl_pkg::PdataW-1:0] prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_stall;
  logic [bl_pkg::TimeW-1:0]  now_ms;
  logic [bl_pkg::PulseW-1:0] pulse_left;
  logic [bl_pkg::PulseW-1:0] pulse_right;
  logic                      out_valid;
  logic                      out_stall;
  logic                      led_left;
  logic                      led_right;
  logic [bl_pkg::PerW-1:0]   period_left;
  logic [bl_pkg::PerW-1:0]   period_right;

  lamp_scoreboard            sb;
  int                        send_idle;
  int                        stall_pct;
  int                        cycle_count;
  logic [bl_pkg::TimeW-1:0]  clock_ms;

  dual_pwm_speed_led_blinker DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_transfer(now_ms, pulse_left, pulse_right);
      if (out_valid && !out_stall)
        sb.check_transfer(led_left, led_right, period_left, period_right);
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(logic [bl_pkg::TimeW-1:0] now,
                           logic [bl_pkg::PulseW-1:0] left,
                           logic [bl_pkg::PulseW-1:0] right);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    now_ms = now;
    pulse_left = left;
    pulse_right = right;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [bl_pkg::PdataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(int pmin, int pmax, int neutral, int dead, int full);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(bl_pkg::REG_PULSE_MIN, pmin);
    write_reg(bl_pkg::REG_PULSE_MAX, pmax);
    write_reg(bl_pkg::REG_PULSE_NEUTRAL, neutral);
    write_reg(bl_pkg::REG_DEAD_BAND, dead);
    write_reg(bl_pkg::REG_FULL_DEFLECTION, full);
  endtask

  function automatic logic [bl_pkg::PulseW-1:0] pick_pulse();
    int sel, span, v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      span = int'(sb.full_deflection) + 64;
      v = int'(sb.pulse_neutral) - span + int'($urandom_range(2 * span));
    end else if (sel < 85) begin
      v = int'(sb.dead_band) + int'($urandom_range(2)) - 1;
      v = $urandom_range(1) ? int'(sb.pulse_neutral) + v : int'(sb.pulse_neutral) - v;
    end else begin
      v = $urandom_range(4095);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[bl_pkg::PulseW-1:0];
  endfunction

  task automatic run_random(int count, int idle_s, int stall_r);
    int sel;
    send_idle = idle_s;
    stall_pct = stall_r;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      sel = $urandom_range(99);
      if (sel < 8) clock_ms = $urandom();
      else if (sel < 15) clock_ms = clock_ms;
      else clock_ms = clock_ms + $urandom_range(1500);
      send_item(clock_ms, pick_pulse(), pick_pulse());
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    now_ms = '0;
    pulse_left = '0;
    pulse_right = '0;
    out_stall = 1'b0;
    send_idle = 0;
    stall_pct = 0;
    cycle_count = 0;
    clock_ms = '0;
    sb = new();
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send_item(32'd0, 12'd0, 12'd4095);
    send_item(32'd101, 12'd1500, 12'd1500);
    send_item(32'd200, 12'd1525, 12'd1475);
    send_item(32'd300, 12'd1526, 12'd1474);
    send_item(32'd999, 12'd1526, 12'd1474);
    send_item(32'd1998, 12'd1100, 12'd1900);
    send_item(32'd2099, 12'd1099, 12'd1901);
    send_item(32'd2100, 12'd2000, 12'd1000);
    send_item(32'hFFFF_FFFF, 12'd4095, 12'd0);
    send_item(32'd0, 12'd4095, 12'd0);
    send_item(32'd99, 12'd4095, 12'd0);
    send_item(32'd100, 12'd4095, 12'd0);
    send_item(32'h8000_0000, 12'hAAA, 12'h555);
    send_item(32'h7FFF_FFFF, 12'h555, 12'hAAA);
    send_item(32'h5555_5555, 12'd1700, 12'd1300);
    send_item(32'hAAAA_AAAA, 12'd1300, 12'd1700);

    configure(1000, 2000, 1500, 0, 2047);
    run_random(150, 0, 0);
    configure(4095, 0, 0, 1023, 1);
    run_random(60, 67, 0);
    configure(0, 4095, 2048, 300, 300);
    run_random(60, 0, 67);
    configure(0, 4095, 2048, 500, 200);
    run_random(80, 10, 10);
    configure(0, 0, 0, 0, 1);
    run_random(20, 67, 67);
    configure(1100, 1900, 1500, 25, 400);
    clock_ms = 32'hFFFF_F000;
    run_random(150, 10, 10);
    configure(0, 4095, 4095, 1023, 2047);
    run_random(80, 67, 0);
    configure(1200, 1800, 1500, 10, 250);
    run_random(140, 0, 67);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
